/* hw/rtl/sbm_pkg.sv */
// Shared types and constants for the stack bytecode machine.
`timescale 1ns / 1ps
package sbm_pkg;

   localparam int PTR_W = 19;

   // Configuration register index on the csr port.
   localparam logic [1:0] REG_ENTRY_PC = 2'd0;

   typedef struct packed {
      logic [1:0]         command;
      logic [17:0]        address;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] data_out;
      logic signed [31:0] acc_out;
      logic [18:0]        pc_out;
      logic [7:0]         opcode_seen;
   } rsp_type;

   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_STEP    = 2'd2;
   localparam logic [1:0] CMD_RESTART = 2'd3;

   localparam logic [2:0] ST_DONE    = 3'd0;
   localparam logic [2:0] ST_STEPPED = 3'd1;
   localparam logic [2:0] ST_EXITED  = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_HOST    = 3'd4;
   localparam logic [2:0] ST_HALTED  = 3'd5;

   localparam logic [31:0] OP_LEA = 32'd0;
   localparam logic [31:0] OP_IMM = 32'd1;
   localparam logic [31:0] OP_JMP = 32'd2;
   localparam logic [31:0] OP_JSR = 32'd3;
   localparam logic [31:0] OP_BZ  = 32'd4;
   localparam logic [31:0] OP_BNZ = 32'd5;
   localparam logic [31:0] OP_ENT = 32'd6;
   localparam logic [31:0] OP_ADJ = 32'd7;
   localparam logic [31:0] OP_LEV = 32'd8;
   localparam logic [31:0] OP_LI  = 32'd9;
   localparam logic [31:0] OP_LC  = 32'd10;
   localparam logic [31:0] OP_SI  = 32'd11;
   localparam logic [31:0] OP_SC  = 32'd12;
   localparam logic [31:0] OP_PSH = 32'd13;
   localparam logic [31:0] OP_OR  = 32'd14;
   localparam logic [31:0] OP_XOR = 32'd15;
   localparam logic [31:0] OP_AND = 32'd16;
   localparam logic [31:0] OP_EQ  = 32'd17;
   localparam logic [31:0] OP_NE  = 32'd18;
   localparam logic [31:0] OP_LT  = 32'd19;
   localparam logic [31:0] OP_GT  = 32'd20;
   localparam logic [31:0] OP_LE  = 32'd21;
   localparam logic [31:0] OP_GE  = 32'd22;
   localparam logic [31:0] OP_SHL = 32'd23;
   localparam logic [31:0] OP_SHR = 32'd24;
   localparam logic [31:0] OP_ADD = 32'd25;
   localparam logic [31:0] OP_SUB = 32'd26;
   localparam logic [31:0] OP_MUL = 32'd27;
   localparam logic [31:0] OP_DIV = 32'd28;
   localparam logic [31:0] OP_MOD = 32'd29;
   localparam logic [31:0] OP_OPEN = 32'd30;
   localparam logic [31:0] OP_MCMP = 32'd36;
   localparam logic [31:0] OP_EXIT = 32'd37;

   // Datapath register selection for the memory address.
   typedef enum logic [2:0] {
      ADR_REQ = 3'd0, ADR_PC = 3'd1, ADR_SP = 3'd2, ADR_ACC = 3'd3, ADR_POP = 3'd4
   } adr_sel_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic        capture_req;
      logic        mem_rd;
      adr_sel_type adr_sel;
      logic        op_latch;    // store read word as opcode
      logic        opnd_latch;  // store read word as operand
      logic        pop_latch;   // store read word as popped value
      logic        pc_inc;
      logic        sp_inc;
      logic        sp_dec;
      logic        sp_load_bp;  // copy the frame pointer into the stack pointer
      logic        exec;        // execute the pending opcode's final effect
      logic        div_start;
      logic        restart;
      logic        mem_wr_req;
      logic        finish;      // present the result
      logic [2:0]  status;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic [31:0] opcode;
      logic        div_busy;
   } stat_type;

endpackage

/* hw/rtl/sbm_divider.sv */
// Radix-two signed divider with the machine's divide-by-zero rules.
`timescale 1ns / 1ps
module sbm_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic [5:0]  count_ff, count_in;
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic        nq_ff, nq_in, nr_ff, nr_in, zero_ff, zero_in;
   logic [31:0] a_ff, a_in;
   logic [32:0] trial;

   assign trial = {r_ff, q_ff[31]} - {1'b0, d_ff};

   always_comb begin
      count_in = count_ff;
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      nq_in = nq_ff; nr_in = nr_ff; zero_in = zero_ff; a_in = a_ff;
      if (start) begin
         count_in = 6'd32;
         q_in = dividend[31] ? 32'd0 - dividend : dividend;
         d_in = divisor[31] ? 32'd0 - divisor : divisor;
         r_in = 32'd0;
         nq_in = dividend[31] ^ divisor[31];
         nr_in = dividend[31];
         zero_in = (divisor == 32'd0);
         a_in = dividend;
      end else if (count_ff != 6'd0) begin
         count_in = count_ff - 6'd1;
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= 6'd0;
      else count_ff <= count_in;
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      nq_ff <= nq_in; nr_ff <= nr_in; zero_ff <= zero_in; a_ff <= a_in;
   end

   assign busy = (count_ff != 6'd0);
   assign quotient  = zero_ff ? 32'hFFFF_FFFF : (nq_ff ? 32'd0 - q_ff : q_ff);
   assign remainder = zero_ff ? a_ff : (nr_ff ? 32'd0 - r_ff : r_ff);
endmodule

/* hw/rtl/sbm_datapath.sv */
// Datapath: machine registers, unified memory and the ALU.
`timescale 1ns / 1ps
module sbm_datapath #(
   parameter int MEM_WORDS = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  sbm_pkg::req_type    req,
   input  logic [17:0]         entry_pc,
   input  sbm_pkg::cmd_type    cmd,
   output sbm_pkg::stat_type   stat,
   output sbm_pkg::rsp_type    rsp
);
   localparam int IDX_W = $clog2(MEM_WORDS);
   localparam int PW = sbm_pkg::PTR_W;
   localparam logic [PW-1:0] TOP = PW'((64'(MEM_WORDS) * 64'd4) & 64'h7FFFF);

   logic [31:0] mem [MEM_WORDS];
   logic [31:0] rdata_ff;

   sbm_pkg::req_type req_ff;
   logic [31:0]   acc_ff, acc_in, op_ff, opnd_ff, pop_ff, data_ff, data_in;
   logic [PW-1:0] pc_ff, pc_in, sp_ff, sp_in, bp_ff, bp_in;
   logic [PW-1:0] addr;
   logic [IDX_W-1:0] idx;
   logic        wr_en;
   logic [31:0] wr_data;
   logic [31:0] quo, rem;
   logic        div_busy;
   logic [4:0]  sh;
   logic [31:0] sc_word, lc_byte;

   sbm_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(pop_ff), .divisor(acc_ff),
      .busy(div_busy), .quotient(quo), .remainder(rem)
   );

   always_comb begin
      case (cmd.adr_sel)
         sbm_pkg::ADR_REQ: addr = {1'b0, req_ff.address};
         sbm_pkg::ADR_PC:  addr = pc_ff;
         sbm_pkg::ADR_SP:  addr = sp_ff;
         sbm_pkg::ADR_ACC: addr = acc_ff[PW-1:0];
         sbm_pkg::ADR_POP: addr = pop_ff[PW-1:0];
         default:          addr = pc_ff;
      endcase
   end
   assign idx = IDX_W'(addr >> 2);

   // Byte lane of SC and LC relative to the byte address.
   assign sh = {addr[1:0], 3'b000};
   assign lc_byte = 32'(rdata_ff >> sh);
   assign sc_word = (rdata_ff & ~(32'hFF << sh)) | ({24'd0, acc_ff[7:0]} << sh);

   always_comb begin
      wr_en = 1'b0;
      wr_data = req_ff.value;
      if (cmd.mem_wr_req) begin
         wr_en = 1'b1;
         case (op_ff)
            sbm_pkg::OP_SI:  wr_data = acc_ff;
            sbm_pkg::OP_SC:  wr_data = sc_word;
            sbm_pkg::OP_JSR: wr_data = {13'd0, PW'(pc_ff + PW'(4))};
            sbm_pkg::OP_ENT: wr_data = {13'd0, bp_ff};
            sbm_pkg::OP_PSH: wr_data = acc_ff;
            default:         wr_data = req_ff.value;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[idx] <= wr_data;
      if (cmd.mem_rd) rdata_ff <= mem[idx];
   end

   always_comb begin
      acc_in = acc_ff; pc_in = pc_ff; sp_in = sp_ff; bp_in = bp_ff; data_in = data_ff;
      if (cmd.pc_inc) pc_in = pc_ff + PW'(4);
      if (cmd.sp_inc) sp_in = sp_ff + PW'(4);
      if (cmd.sp_dec) sp_in = sp_ff - PW'(4);
      if (cmd.sp_load_bp) sp_in = bp_ff;
      if (cmd.capture_req) data_in = 32'd0;
      if (cmd.restart) begin
         pc_in = {1'b0, entry_pc}; sp_in = TOP; bp_in = TOP; acc_in = 32'd0;
      end
      if (cmd.exec) begin
         case (op_ff)
            sbm_pkg::OP_LEA: acc_in = {13'd0, PW'(bp_ff + PW'(opnd_ff << 2))};
            sbm_pkg::OP_IMM: acc_in = opnd_ff;
            sbm_pkg::OP_JMP: pc_in = opnd_ff[PW-1:0];
            sbm_pkg::OP_JSR: pc_in = opnd_ff[PW-1:0];
            sbm_pkg::OP_BZ:  pc_in = (acc_ff != 0) ? pc_ff + PW'(4) : opnd_ff[PW-1:0];
            sbm_pkg::OP_BNZ: pc_in = (acc_ff != 0) ? opnd_ff[PW-1:0] : pc_ff + PW'(4);
            sbm_pkg::OP_ENT: begin
               bp_in = sp_ff;
               sp_in = sp_ff - PW'(opnd_ff << 2);
            end
            sbm_pkg::OP_ADJ: sp_in = sp_ff + PW'(opnd_ff << 2);
            sbm_pkg::OP_LEV: begin
               // Two pops already done: pop_ff holds return pc, opnd_ff the saved bp.
               bp_in = opnd_ff[PW-1:0];
               pc_in = pop_ff[PW-1:0];
            end
            sbm_pkg::OP_LI:  acc_in = rdata_ff;
            sbm_pkg::OP_LC:  acc_in = {{24{lc_byte[7]}}, lc_byte[7:0]};
            sbm_pkg::OP_SC:  acc_in = {{24{acc_ff[7]}}, acc_ff[7:0]};
            sbm_pkg::OP_OR:  acc_in = pop_ff | acc_ff;
            sbm_pkg::OP_XOR: acc_in = pop_ff ^ acc_ff;
            sbm_pkg::OP_AND: acc_in = pop_ff & acc_ff;
            sbm_pkg::OP_EQ:  acc_in = {31'd0, pop_ff == acc_ff};
            sbm_pkg::OP_NE:  acc_in = {31'd0, pop_ff != acc_ff};
            sbm_pkg::OP_LT:  acc_in = {31'd0, $signed(pop_ff) < $signed(acc_ff)};
            sbm_pkg::OP_GT:  acc_in = {31'd0, $signed(acc_ff) < $signed(pop_ff)};
            sbm_pkg::OP_LE:  acc_in = {31'd0, !($signed(acc_ff) < $signed(pop_ff))};
            sbm_pkg::OP_GE:  acc_in = {31'd0, !($signed(pop_ff) < $signed(acc_ff))};
            sbm_pkg::OP_SHL: acc_in = pop_ff << acc_ff[4:0];
            sbm_pkg::OP_SHR: acc_in = 32'($signed(pop_ff) >>> acc_ff[4:0]);
            sbm_pkg::OP_ADD: acc_in = pop_ff + acc_ff;
            sbm_pkg::OP_SUB: acc_in = pop_ff - acc_ff;
            sbm_pkg::OP_MUL: acc_in = 32'(pop_ff * acc_ff);
            sbm_pkg::OP_DIV: acc_in = quo;
            sbm_pkg::OP_MOD: acc_in = rem;
            sbm_pkg::OP_EXIT: data_in = rdata_ff;
            default: ;
         endcase
      end
      if (cmd.finish && req_ff.command == sbm_pkg::CMD_READ) data_in = rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 32'd0; pc_ff <= '0; sp_ff <= TOP; bp_ff <= TOP;
      end else begin
         acc_ff <= acc_in; pc_ff <= pc_in; sp_ff <= sp_in; bp_ff <= bp_in;
      end
      data_ff <= data_in;
      if (cmd.capture_req) begin
         req_ff <= req;
         op_ff <= 32'd0;
      end
      if (cmd.op_latch) op_ff <= rdata_ff;
      if (cmd.opnd_latch) opnd_ff <= rdata_ff;
      if (cmd.pop_latch) pop_ff <= rdata_ff;
   end

   assign stat.opcode = op_ff;
   assign stat.div_busy = div_busy;

   assign rsp.status = cmd.status;
   assign rsp.data_out = data_in;
   assign rsp.acc_out = acc_ff;
   assign rsp.pc_out = pc_ff;
   assign rsp.opcode_seen = op_ff[7:0];
endmodule

/* hw/rtl/sbm_control.sv */
// Controller: sequences memory accesses for each command and instruction.
`timescale 1ns / 1ps
module sbm_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        command,
   output logic              busy,
   input  sbm_pkg::stat_type stat,
   output sbm_pkg::cmd_type  cmd,
   output logic              done
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_ACC   = 11'b00000000010,
      S_FETCH = 11'b00000000100,
      S_DEC   = 11'b00000001000,
      S_OPND  = 11'b00000010000,
      S_MEM   = 11'b00000100000,
      S_POP   = 11'b00001000000,
      S_POP2  = 11'b00010000000,
      S_DIV   = 11'b00100000000,
      S_EXEC  = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic halted_ff, halted_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [2:0] status_ff, status_in;
   logic [1:0] phase_ff, phase_in;
   logic [31:0] op;

   assign op = stat.opcode;
   assign busy = (state_ff != S_IDLE);

   function automatic logic has_opnd(input logic [31:0] o);
      return o == sbm_pkg::OP_LEA || o == sbm_pkg::OP_IMM || o == sbm_pkg::OP_JMP ||
             o == sbm_pkg::OP_JSR || o == sbm_pkg::OP_BZ || o == sbm_pkg::OP_BNZ ||
             o == sbm_pkg::OP_ENT || o == sbm_pkg::OP_ADJ;
   endfunction

   function automatic logic is_binop(input logic [31:0] o);
      return o >= sbm_pkg::OP_OR && o <= sbm_pkg::OP_MOD;
   endfunction

   always_comb begin
      state_in = state_ff; halted_in = halted_ff; cmd_in = cmd_ff;
      status_in = status_ff; phase_in = phase_ff;
      cmd = '0;
      cmd.adr_sel = sbm_pkg::ADR_PC;
      cmd.status = status_ff;
      done = 1'b0;
      case (state_ff)
         S_IDLE: if (start) begin
            cmd.capture_req = 1'b1;
            cmd_in = command;
            status_in = sbm_pkg::ST_DONE;
            phase_in = 2'd0;
            if (command == sbm_pkg::CMD_STEP) begin
               if (halted_ff) begin
                  status_in = sbm_pkg::ST_HALTED;
                  state_in = S_OUT;
               end else state_in = S_FETCH;
            end else if (command == sbm_pkg::CMD_RESTART) begin
               state_in = S_OUT;
            end else state_in = S_ACC;
         end
         S_ACC: begin
            cmd.adr_sel = sbm_pkg::ADR_REQ;
            if (cmd_ff == sbm_pkg::CMD_WRITE) cmd.mem_wr_req = 1'b1;
            else cmd.mem_rd = 1'b1;
            state_in = S_OUT;
         end
         S_FETCH: begin
            cmd.mem_rd = 1'b1; cmd.pc_inc = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            cmd.op_latch = 1'b1;
            state_in = S_OPND;
         end
         S_OPND: begin
            // Opcode is now registered: choose the access that follows.
            status_in = sbm_pkg::ST_STEPPED;
            if (has_opnd(op)) begin
               cmd.mem_rd = 1'b1;
               if (op != sbm_pkg::OP_JMP && op != sbm_pkg::OP_JSR &&
                   op != sbm_pkg::OP_BZ && op != sbm_pkg::OP_BNZ) cmd.pc_inc = 1'b1;
               state_in = S_MEM;
            end else if (op == sbm_pkg::OP_LI || op == sbm_pkg::OP_LC) begin
               cmd.mem_rd = 1'b1; cmd.adr_sel = sbm_pkg::ADR_ACC;
               state_in = S_EXEC;
            end else if (op == sbm_pkg::OP_SI || op == sbm_pkg::OP_SC ||
                         is_binop(op)) begin
               cmd.mem_rd = 1'b1; cmd.adr_sel = sbm_pkg::ADR_SP; cmd.sp_inc = 1'b1;
               state_in = S_POP;
            end else if (op == sbm_pkg::OP_PSH) begin
               cmd.sp_dec = 1'b1;
               state_in = S_MEM;
            end else if (op == sbm_pkg::OP_LEV) begin
               phase_in = 2'd0;
               state_in = S_POP2;
            end else if (op == sbm_pkg::OP_EXIT) begin
               cmd.mem_rd = 1'b1; cmd.adr_sel = sbm_pkg::ADR_SP;
               status_in = sbm_pkg::ST_EXITED; halted_in = 1'b1;
               state_in = S_EXEC;
            end else begin
               halted_in = 1'b1;
               status_in = (op >= sbm_pkg::OP_OPEN && op <= sbm_pkg::OP_MCMP) ?
                           sbm_pkg::ST_HOST : sbm_pkg::ST_UNKNOWN;
               state_in = S_OUT;
            end
         end
         S_MEM: begin
            if (op == sbm_pkg::OP_PSH) begin
               cmd.adr_sel = sbm_pkg::ADR_SP; cmd.mem_wr_req = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.opnd_latch = 1'b1;
               if (op == sbm_pkg::OP_JSR || op == sbm_pkg::OP_ENT) begin
                  cmd.sp_dec = 1'b1;
                  state_in = S_DIV;
               end else state_in = S_EXEC;
            end
         end
         S_POP: begin
            cmd.pop_latch = 1'b1;
            if (op == sbm_pkg::OP_DIV || op == sbm_pkg::OP_MOD) state_in = S_DIV;
            else if (op == sbm_pkg::OP_SC) state_in = S_POP2;
            else if (op == sbm_pkg::OP_SI) begin
               state_in = S_DIV;
            end else state_in = S_EXEC;
         end
         S_POP2: begin
            if (op == sbm_pkg::OP_SC) begin
               // Read the target word before merging the byte.
               cmd.mem_rd = 1'b1; cmd.adr_sel = sbm_pkg::ADR_POP;
               state_in = S_DIV;
            end else begin
               // LEV: sp <- bp, then pop saved bp and return pc.
               case (phase_ff)
                  2'd0: begin
                     cmd.sp_load_bp = 1'b1;
                     phase_in = 2'd1;
                  end
                  2'd1: begin
                     cmd.mem_rd = 1'b1; cmd.adr_sel = sbm_pkg::ADR_SP; cmd.sp_inc = 1'b1;
                     phase_in = 2'd2;
                  end
                  2'd2: begin
                     cmd.opnd_latch = 1'b1;
                     cmd.mem_rd = 1'b1; cmd.adr_sel = sbm_pkg::ADR_SP; cmd.sp_inc = 1'b1;
                     phase_in = 2'd3;
                  end
                  default: begin
                     cmd.pop_latch = 1'b1;
                     state_in = S_EXEC;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (op == sbm_pkg::OP_DIV || op == sbm_pkg::OP_MOD) begin
               if (phase_ff == 2'd0) begin
                  cmd.div_start = 1'b1; phase_in = 2'd1;
               end else if (!stat.div_busy) state_in = S_EXEC;
            end else if (op == sbm_pkg::OP_SI) begin
               cmd.adr_sel = sbm_pkg::ADR_POP; cmd.mem_wr_req = 1'b1;
               state_in = S_OUT;
            end else if (op == sbm_pkg::OP_SC) begin
               cmd.adr_sel = sbm_pkg::ADR_POP; cmd.mem_wr_req = 1'b1;
               state_in = S_EXEC;
            end else begin
               // JSR and ENT push their word at the new stack pointer.
               cmd.adr_sel = sbm_pkg::ADR_SP; cmd.mem_wr_req = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (op == sbm_pkg::OP_SC) cmd.adr_sel = sbm_pkg::ADR_POP;
            else if (op == sbm_pkg::OP_LC) cmd.adr_sel = sbm_pkg::ADR_ACC;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (cmd_ff == sbm_pkg::CMD_RESTART) begin
               cmd.restart = 1'b1; halted_in = 1'b0;
               state_in = S_ACC;
               cmd_in = sbm_pkg::CMD_STEP;
               status_in = sbm_pkg::ST_DONE;
            end else begin
               cmd.finish = 1'b1; done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; halted_ff <= 1'b1;
         cmd_ff <= sbm_pkg::CMD_WRITE; status_ff <= sbm_pkg::ST_DONE; phase_ff <= 2'd0;
      end else begin
         state_ff <= state_in; halted_ff <= halted_in; cmd_ff <= cmd_in;
         status_ff <= status_in; phase_ff <= phase_in;
      end
   end
endmodule

/* hw/rtl/stack_bytecode_machine_step.sv */
// Top level of the stack bytecode machine: register port, controller, datapath.
// An item is taken when start is high and busy is low; its result appears on the
// rsp_ ports for one cycle with rsp_valid and cannot be held off. Each executed
// instruction follows the single-port memory's sequence of opcode fetch, operand
// fetch, stack pop and push; divide and modulo also wait for the radix-two divider.
// Memory is not cleared after reset.
`timescale 1ns / 1ps
module stack_bytecode_machine_step #(
   parameter int MEM_WORDS = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sbm_pkg::req_type req_data,
   output logic             rsp_valid,
   output sbm_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [1:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   logic [17:0] entry_pc_ff;
   sbm_pkg::cmd_type  cmd;
   sbm_pkg::stat_type stat;
   logic done;

   assign pready = 1'b1;
   assign prdata = (paddr == sbm_pkg::REG_ENTRY_PC) ? {14'd0, entry_pc_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) entry_pc_ff <= 18'd0;
      else if (psel && penable && pwrite && paddr == sbm_pkg::REG_ENTRY_PC)
         entry_pc_ff <= pwdata[17:0];
   end

   sbm_control u_ctl (
      .clock(clock), .reset(reset), .start(start), .command(req_data.command),
      .busy(busy), .stat(stat), .cmd(cmd), .done(done)
   );

   sbm_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .entry_pc(entry_pc_ff),
      .cmd(cmd), .stat(stat), .rsp(rsp_data)
   );

   assign rsp_valid = done;
endmodule

/* hw/rtl/sbm_checker.sv */
// Port-level checks for the stack bytecode machine.
`timescale 1ns / 1ps
module sbm_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input sbm_pkg::rsp_type rsp_data
);
   a_acc_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("item taken without going busy");
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside an item");
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= 3'd5) else $error("bad status");
endmodule

bind stack_bytecode_machine_step sbm_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

/* verif/testbench.sv */
// Self-checking testbench for the stack bytecode machine top level.
`timescale 1ns / 1ps
module testbench;

   localparam logic [18:0] MEM_TOP = 19'h40000;
   localparam int N_ITEMS = 1100;

   typedef enum logic {K_REQ, K_CFG} kind_type;
   typedef struct {
      kind_type         kind;
      sbm_pkg::req_type req;
      logic [17:0]      cfg;
   } pend_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   sbm_pkg::req_type req_data = '0;
   logic rsp_valid;
   sbm_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [1:0] paddr = sbm_pkg::REG_ENTRY_PC;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   stack_bytecode_machine_step u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Machine state as the generator sees it, advanced item by item.
   logic [31:0] mem_words [bit [15:0]];
   bit [15:0]   written_q[$];
   logic [31:0] acc = '0;
   logic [18:0] pc = '0;
   logic [18:0] sp = MEM_TOP;
   logic [18:0] bp = MEM_TOP;
   logic        halted = 1'b1;
   logic [17:0] entry = '0;

   pend_type pending[$];
   sbm_pkg::rsp_type expected_q[$];
   int n_items = 0;
   int n_sent = 0;
   int n_recv = 0;
   int errors = 0;
   bit gen_done = 0;

   function automatic logic [31:0] word_at(logic [31:0] addr);
      return mem_words[addr[17:2]];
   endfunction

   function automatic logic [18:0] to_ptr(logic [31:0] w);
      return w[18:0];
   endfunction

   function automatic void store_word(logic [31:0] addr, logic [31:0] v);
      if (!mem_words.exists(addr[17:2])) written_q.push_back(addr[17:2]);
      mem_words[addr[17:2]] = v;
   endfunction

   function automatic logic [31:0] fetch_word();
      logic [31:0] w;
      w = word_at({13'd0, pc});
      pc = pc + 19'd4;
      return w;
   endfunction

   function automatic logic [31:0] pop_word();
      logic [31:0] w;
      w = word_at({13'd0, sp});
      sp = sp + 19'd4;
      return w;
   endfunction

   function automatic void push_word(logic [31:0] v);
      sp = sp - 19'd4;
      store_word({13'd0, sp}, v);
   endfunction

   function automatic logic [31:0] sext_byte(logic [7:0] b);
      return {{24{b[7]}}, b};
   endfunction

   function automatic logic [31:0] less_than(logic [31:0] a, logic [31:0] b);
      return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
   endfunction

   function automatic logic [31:0] divide(logic [31:0] a, logic [31:0] b, bit want_rest);
      logic [31:0] ua, ub, q, r;
      if (b == 0) return want_rest ? a : 32'hFFFF_FFFF;
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      q = ua / ub;
      r = ua % ub;
      if (a[31] != b[31]) q = -q;
      if (a[31]) r = -r;
      return want_rest ? r : q;
   endfunction

   function automatic void run_instruction(ref sbm_pkg::rsp_type e);
      logic [31:0] op, a, t, w;
      op = fetch_word();
      e.opcode_seen = op[7:0];
      e.status = sbm_pkg::ST_STEPPED;
      case (op)
         sbm_pkg::OP_LEA: begin
            t = {13'd0, bp} + fetch_word() * 4;
            acc = {13'd0, t[18:0]};
         end
         sbm_pkg::OP_IMM: acc = fetch_word();
         sbm_pkg::OP_JMP: pc = to_ptr(word_at({13'd0, pc}));
         sbm_pkg::OP_JSR: begin
            push_word({13'd0, pc + 19'd4});
            pc = to_ptr(word_at({13'd0, pc}));
         end
         sbm_pkg::OP_BZ:  pc = (acc != 0) ? pc + 19'd4 : to_ptr(word_at({13'd0, pc}));
         sbm_pkg::OP_BNZ: pc = (acc != 0) ? to_ptr(word_at({13'd0, pc})) : pc + 19'd4;
         sbm_pkg::OP_ENT: begin
            t = fetch_word();
            push_word({13'd0, bp});
            bp = sp;
            w = {13'd0, sp} - t * 4;
            sp = w[18:0];
         end
         sbm_pkg::OP_ADJ: begin
            w = {13'd0, sp} + fetch_word() * 4;
            sp = w[18:0];
         end
         sbm_pkg::OP_LEV: begin
            sp = bp;
            w = pop_word();
            bp = w[18:0];
            w = pop_word();
            pc = w[18:0];
         end
         sbm_pkg::OP_LI: acc = word_at(acc);
         sbm_pkg::OP_LC: begin
            w = word_at(acc) >> {acc[1:0], 3'b000};
            acc = sext_byte(w[7:0]);
         end
         sbm_pkg::OP_SI: begin
            a = pop_word();
            store_word(a, acc);
         end
         sbm_pkg::OP_SC: begin
            a = pop_word();
            t = {27'd0, a[1:0], 3'b000};
            store_word(a, (word_at(a) & ~(32'hFF << t)) | ({24'd0, acc[7:0]} << t));
            acc = sext_byte(acc[7:0]);
         end
         sbm_pkg::OP_PSH: push_word(acc);
         sbm_pkg::OP_OR:  acc = pop_word() | acc;
         sbm_pkg::OP_XOR: acc = pop_word() ^ acc;
         sbm_pkg::OP_AND: acc = pop_word() & acc;
         sbm_pkg::OP_EQ:  acc = (pop_word() == acc) ? 32'd1 : 32'd0;
         sbm_pkg::OP_NE:  acc = (pop_word() != acc) ? 32'd1 : 32'd0;
         sbm_pkg::OP_LT:  acc = less_than(pop_word(), acc);
         sbm_pkg::OP_GT: begin
            a = pop_word();
            acc = less_than(acc, a);
         end
         sbm_pkg::OP_LE: begin
            a = pop_word();
            acc = less_than(acc, a) ^ 32'd1;
         end
         sbm_pkg::OP_GE:  acc = less_than(pop_word(), acc) ^ 32'd1;
         sbm_pkg::OP_SHL: acc = pop_word() << acc[4:0];
         sbm_pkg::OP_SHR: acc = $signed(pop_word()) >>> acc[4:0];
         sbm_pkg::OP_ADD: acc = pop_word() + acc;
         sbm_pkg::OP_SUB: acc = pop_word() - acc;
         sbm_pkg::OP_MUL: acc = pop_word() * acc;
         sbm_pkg::OP_DIV: acc = divide(pop_word(), acc, 1'b0);
         sbm_pkg::OP_MOD: acc = divide(pop_word(), acc, 1'b1);
         sbm_pkg::OP_EXIT: begin
            e.data_out = word_at({13'd0, sp});
            halted = 1'b1;
            e.status = sbm_pkg::ST_EXITED;
         end
         default: begin
            halted = 1'b1;
            e.status = (op >= sbm_pkg::OP_OPEN && op <= sbm_pkg::OP_MCMP) ?
                       sbm_pkg::ST_HOST : sbm_pkg::ST_UNKNOWN;
         end
      endcase
   endfunction

   function automatic sbm_pkg::rsp_type predict_item(sbm_pkg::req_type r);
      sbm_pkg::rsp_type e;
      e = '0;
      case (r.command)
         sbm_pkg::CMD_WRITE: store_word({14'd0, r.address}, r.value);
         sbm_pkg::CMD_READ:  e.data_out = word_at({14'd0, r.address});
         sbm_pkg::CMD_STEP: begin
            if (halted) e.status = sbm_pkg::ST_HALTED;
            else run_instruction(e);
         end
         default: begin
            pc = {1'b0, entry};
            sp = MEM_TOP;
            bp = MEM_TOP;
            acc = '0;
            halted = 1'b0;
         end
      endcase
      e.acc_out = acc;
      e.pc_out = pc;
      return e;
   endfunction

   function automatic void emit(logic [1:0] cmd, logic [31:0] addr, logic [31:0] v);
      pend_type p;
      p.kind = K_REQ;
      p.req.command = cmd;
      p.req.address = addr[17:0];
      p.req.value = v;
      p.cfg = '0;
      expected_q.push_back(predict_item(p.req));
      pending.push_back(p);
      n_items++;
   endfunction

   function automatic void emit_cfg(logic [17:0] v);
      pend_type p;
      p.kind = K_CFG;
      p.req = '0;
      p.cfg = v;
      entry = v;
      pending.push_back(p);
   endfunction

   function automatic logic [31:0] data_word();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 64);
         2: return {14'd0, entry} + $urandom_range(0, 255) * 4;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               default: return 32'd0;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] code_addr();
      return {14'd0, entry} + $urandom_range(0, 31) * 4;
   endfunction

   function automatic logic [31:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, 29);
      if (r < 86) return $urandom_range(30, 37);
      if (r < 90) return $urandom_range(38, 255);
      if (r < 93) return $urandom;
      return sbm_pkg::OP_IMM;
   endfunction

   function automatic logic [31:0] pick_operand(logic [31:0] op);
      case (op)
         sbm_pkg::OP_JMP, sbm_pkg::OP_JSR, sbm_pkg::OP_BZ, sbm_pkg::OP_BNZ:
            return code_addr();
         sbm_pkg::OP_ENT, sbm_pkg::OP_ADJ, sbm_pkg::OP_LEA:
            return $urandom_range(0, 8) - 4;
         default: return data_word();
      endcase
   endfunction

   // Writes a word first wherever the next step would read one never written.
   function automatic void fill_word(logic [31:0] addr, logic [31:0] v);
      if (!mem_words.exists(addr[17:2])) emit(sbm_pkg::CMD_WRITE, addr, v);
   endfunction

   function automatic void step_program(bit fresh, logic [31:0] op_in, logic [31:0] arg);
      logic [31:0] op;
      if (fresh) begin
         emit(sbm_pkg::CMD_WRITE, {13'd0, pc}, op_in);
         if (op_in <= sbm_pkg::OP_ADJ) emit(sbm_pkg::CMD_WRITE, {13'd0, pc} + 4, arg);
      end
      fill_word({13'd0, pc}, pick_op());
      op = word_at({13'd0, pc});
      if (op <= sbm_pkg::OP_ADJ) fill_word({13'd0, pc} + 4, pick_operand(op));
      if (op == sbm_pkg::OP_LEV) begin
         fill_word({13'd0, bp}, data_word());
         fill_word({13'd0, bp} + 4, code_addr());
      end else if (op == sbm_pkg::OP_LI || op == sbm_pkg::OP_LC) begin
         fill_word(acc, data_word());
      end else if (op == sbm_pkg::OP_SI || op == sbm_pkg::OP_EXIT ||
                   (op >= sbm_pkg::OP_OR && op <= sbm_pkg::OP_MOD)) begin
         fill_word({13'd0, sp}, data_word());
      end else if (op == sbm_pkg::OP_SC) begin
         fill_word({13'd0, sp}, data_word());
         fill_word(word_at({13'd0, sp}), data_word());
      end
      emit(sbm_pkg::CMD_STEP, $urandom, $urandom);
   endfunction

   initial begin
      int r, phase;
      logic [31:0] o;
      // Directed part: field extremes, halted step, overflow and zero divisors, exit.
      emit(sbm_pkg::CMD_STEP, 32'h3FFFF, 32'hFFFF_FFFF);
      emit(sbm_pkg::CMD_WRITE, 32'd0, 32'h7FFF_FFFF);
      emit(sbm_pkg::CMD_WRITE, 32'h3FFFF, 32'h8000_0000);
      emit(sbm_pkg::CMD_READ, 32'd3, 32'd0);
      emit(sbm_pkg::CMD_READ, 32'h3FFFC, 32'hFFFF_FFFF);
      emit(sbm_pkg::CMD_RESTART, 32'd0, 32'd0);
      step_program(1, sbm_pkg::OP_IMM, 32'h8000_0000);
      step_program(1, sbm_pkg::OP_PSH, 0);
      step_program(1, sbm_pkg::OP_IMM, 32'hFFFF_FFFF);
      step_program(1, sbm_pkg::OP_DIV, 0);
      step_program(1, sbm_pkg::OP_PSH, 0);
      step_program(1, sbm_pkg::OP_IMM, 32'd0);
      step_program(1, sbm_pkg::OP_MOD, 0);
      step_program(1, sbm_pkg::OP_EXIT, 0);
      emit_cfg(18'h3FFFC);
      emit(sbm_pkg::CMD_RESTART, $urandom, $urandom);
      phase = 0;
      while (n_items < N_ITEMS) begin
         if (n_items > 300 * (phase + 1)) begin
            phase++;
            emit_cfg(phase == 1 ? 18'($urandom) : (phase == 2 ? 18'd0 : 18'($urandom)));
         end
         r = $urandom_range(0, 99);
         if (halted) begin
            if (r < 10) emit(sbm_pkg::CMD_STEP, $urandom, $urandom);
            else if (r < 15) emit(sbm_pkg::CMD_WRITE, $urandom, data_word());
            else emit(sbm_pkg::CMD_RESTART, $urandom, $urandom);
         end else if (r < 5) begin
            emit(sbm_pkg::CMD_WRITE, $urandom, data_word());
         end else if (r < 10) begin
            emit(sbm_pkg::CMD_READ,
                 32'({written_q[$urandom_range(0, written_q.size() - 1)], 2'(r)}),
                 $urandom);
         end else if (r < 13) begin
            emit(sbm_pkg::CMD_RESTART, $urandom, $urandom);
         end else if (r < 55) begin
            o = pick_op();
            step_program(1, o, pick_operand(o));
         end else begin
            step_program(0, 0, 0);
         end
      end
      gen_done = 1;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: bursts of items with random gaps; register writes only when drained.
   logic req_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int settle = 0;
   int apb_phase = 0;
   logic next_start;

   always @(posedge clock) req_taken <= start && !busy;

   always @(negedge clock) begin
      if (!reset) begin
         if (start && !req_taken) begin
            // the item is still waiting for busy to drop
         end else if (apb_phase == 1) begin
            penable <= 1'b1;
            apb_phase = 2;
         end else if (apb_phase == 2) begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            void'(pending.pop_front());
            apb_phase = 0;
         end else begin
            next_start = 1'b0;
            if (pending.size() > 0) begin
               if (pending[0].kind == K_REQ) begin
                  settle = 0;
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     next_start = 1'b1;
                     req_data <= pending[0].req;
                     void'(pending.pop_front());
                     n_sent++;
                     if (burst_left > 0) begin
                        burst_left--;
                     end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                     end
                  end
               end else if (n_sent == n_recv) begin
                  settle++;
                  if (settle > 20) begin
                     psel <= 1'b1;
                     pwrite <= 1'b1;
                     paddr <= sbm_pkg::REG_ENTRY_PC;
                     pwdata <= {14'd0, pending[0].cfg};
                     apb_phase = 1;
                     settle = 0;
                  end
               end
            end
            start <= next_start;
         end
      end
   end

   // Monitor: every strobed result is matched against the oldest prediction.
   always @(posedge clock) begin
      sbm_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         n_recv++;
         if (expected_q.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.data_out !== e.data_out) begin
               $error("data_out: expected %h, got %h", e.data_out, rsp_data.data_out);
               errors++;
            end
            if (rsp_data.acc_out !== e.acc_out) begin
               $error("acc_out: expected %h, got %h", e.acc_out, rsp_data.acc_out);
               errors++;
            end
            if (rsp_data.pc_out !== e.pc_out) begin
               $error("pc_out: expected %h, got %h", e.pc_out, rsp_data.pc_out);
               errors++;
            end
            if (rsp_data.opcode_seen !== e.opcode_seen) begin
               $error("opcode_seen: expected %h, got %h", e.opcode_seen,
                      rsp_data.opcode_seen);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (gen_done && pending.size() == 0 && !start && expected_q.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/sbm_pkg.sv
hw/rtl/sbm_divider.sv
hw/rtl/sbm_datapath.sv
hw/rtl/sbm_control.sv
hw/rtl/stack_bytecode_machine_step.sv
hw/rtl/sbm_checker.sv
verif/testbench.sv
